FILE: rtl/lpc_pkg.sv
// Shared types, constants and helper functions for the lidar point covariance block.
`timescale 1ns / 1ps
package lpc_pkg;

  localparam int unsigned COV_W    = 48;
  localparam int unsigned ROT_W    = 21;
  localparam int unsigned DIV_BITS = 48;
  localparam int unsigned WORLD_SH = 38;

  localparam logic [63:0]        MIN_R2    = 64'd429497;
  localparam logic signed [31:0] TINY_Y    = 32'sd7;
  localparam logic [63:0]        TINY_Y_SQ = 64'd49;

  // configuration register indexes
  localparam logic [2:0] CFG_RANGE_STD = 3'd0;
  localparam logic [2:0] CFG_BEAM_SSQ  = 3'd1;
  localparam logic [2:0] CFG_ROT_ROW0  = 3'd2;
  localparam logic [2:0] CFG_ROT_ROW1  = 3'd3;
  localparam logic [2:0] CFG_ROT_ROW2  = 3'd4;

  typedef struct packed {
    logic [19:0]       range_std;
    logic [31:0]       beam_sine_sq;
    logic [2:0][62:0]  rot;
  } lpc_cfg_t;

  // classified point, y already replaced, r2 taken with that y
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        r2;
    logic               valid;
  } lpc_item_t;

  typedef struct packed {
    logic                    strobe;
    logic                    frame_sel;
    logic signed [COV_W-1:0] xx;
    logic signed [COV_W-1:0] xy;
    logic signed [COV_W-1:0] xz;
    logic signed [COV_W-1:0] yy;
    logic signed [COV_W-1:0] yz;
    logic signed [COV_W-1:0] zz;
    logic                    cov_valid;
    logic                    last;
  } lpc_result_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_RV, BK_PP, BK_PPCAP, BK_NLO, BK_NHI, BK_NWAIT, BK_DINIT, BK_DIV,
    BK_T1, BK_T2LO, BK_T2HI, BK_T2WAIT, BK_BRND,
    BK_RR, BK_RRCAP, BK_CLO, BK_CHI, BK_CWAIT, BK_WRND, BK_OUT0, BK_OUT1
  } lpc_bstate_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_ADD, ACC_SUB} lpc_accop_t;
  typedef enum logic [1:0] {SH_0, SH_24, SH_32} lpc_shift_t;

  // unique entry e -> row / column
  function automatic logic [1:0] ent_i(input logic [2:0] e);
    case (e)
      3'd0, 3'd1, 3'd2: return 2'd0;
      3'd3, 3'd4:       return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] ent_j(input logic [2:0] e);
    case (e)
      3'd0:       return 2'd0;
      3'd1, 3'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  // symmetric (i,j) -> unique entry
  function automatic logic [2:0] ent_idx(input logic [1:0] i, input logic [1:0] j);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    case (lo)
      2'd0:    return {1'b0, hi};
      2'd1:    return 3'(hi) + 3'd2;
      default: return 3'd5;
    endcase
  endfunction

  // term t of the 3x3 sum -> (i,j)
  function automatic logic [1:0] term_i(input logic [3:0] t);
    if (t < 4'd3) return 2'd0;
    else if (t < 4'd6) return 2'd1;
    else return 2'd2;
  endfunction

  function automatic logic [1:0] term_j(input logic [3:0] t);
    case (t)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic signed [31:0] pt_sel(input lpc_item_t it, input logic [1:0] k);
    case (k)
      2'd0:    return it.x;
      2'd1:    return it.y;
      default: return it.z;
    endcase
  endfunction

  function automatic logic signed [ROT_W-1:0] rot_elem(input lpc_cfg_t c,
                                                     input logic [1:0] i,
                                                     input logic [1:0] j);
    logic [62:0] row;
    row = c.rot[i];
    case (j)
      2'd0:    return row[20:0];
      2'd1:    return row[41:21];
      default: return row[62:42];
    endcase
  endfunction

  // round half up by k bits, clamp to 48-bit signed
  function automatic logic signed [COV_W-1:0] round_sat(input logic signed [127:0] a,
                                                        input int unsigned k);
    logic signed [127:0] b;
    logic signed [127:0] s;
    b = a + $signed(128'(1) << (k - 1));
    s = b >>> k;
    if (!((&s[127:COV_W-1]) || (~|s[127:COV_W-1])))
      return s[127] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    return s[COV_W-1:0];
  endfunction

endpackage

FILE: rtl/lpc_queue.sv
// Two-entry request queue between the classifier and the covariance engine.
`timescale 1ns / 1ps
module lpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpc_pkg::lpc_item_t push_data,
  output logic              full,
  input  logic              pop,
  output lpc_pkg::lpc_item_t pop_data,
  output logic              empty
);
  import lpc_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  lpc_item_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/lpc_front.sv
// Front end: takes points, squares the coordinates, classifies and queues them.
`timescale 1ns / 1ps
module lpc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               in_no_return,
  output logic               push,
  output lpc_pkg::lpc_item_t push_data,
  input  logic               q_full
);
  import lpc_pkg::*;

  logic               s1_v_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic               nr_r;
  logic [63:0]        sqx_r, sqy_r, sqz_r;
  logic               accept;
  logic [63:0]        r2;
  logic               y_zero;

  assign busy   = s1_v_r && q_full;
  assign accept = start && !busy;
  assign push   = s1_v_r && !q_full;

  // validity uses the range before the zero-y fix
  always_comb begin
    r2     = sqx_r + sqy_r + sqz_r;
    y_zero = (y_r == '0);
    push_data.x     = x_r;
    push_data.y     = y_zero ? TINY_Y : y_r;
    push_data.z     = z_r;
    push_data.r2    = y_zero ? r2 + TINY_Y_SQ : r2;
    push_data.valid = !nr_r && (r2 >= MIN_R2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (accept) s1_v_r <= 1'b1;
    else if (push) s1_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= in_point_x;
      y_r   <= in_point_y;
      z_r   <= in_point_z;
      nr_r  <= in_no_return;
      sqx_r <= 64'(in_point_x * in_point_x);
      sqy_r <= 64'(in_point_y * in_point_y);
      sqz_r <= 64'(in_point_z * in_point_z);
    end
  end

endmodule

FILE: rtl/lpc_back.sv
// Back end: sequenced multiply-accumulate and divide engine for body and world covariance.
`timescale 1ns / 1ps
module lpc_back #(
  parameter int unsigned COV_FRAC_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpc_pkg::lpc_cfg_t   cfg,
  input  logic                q_empty,
  input  lpc_pkg::lpc_item_t  q_data,
  output logic                q_pop,
  output lpc_pkg::lpc_result_t res
);
  import lpc_pkg::*;

  localparam int unsigned BODY_SH = 64 - COV_FRAC_BITS;

  lpc_bstate_t          state_r, state_nxt;
  lpc_item_t            item_r;
  logic [2:0]           e_r;
  logic [3:0]           t_r;
  logic [5:0]           cnt_r;
  logic [39:0]          rv_r;
  logic signed [63:0]   pp_r;
  logic signed [41:0]   rr_r;
  logic signed [74:0]   mul_r;
  lpc_accop_t           op_r, op_nxt;
  lpc_shift_t           sh_r, sh_nxt;
  logic signed [127:0]  acc_r, acc_nxt;
  logic [63:0]          rem_r;
  logic [47:0]          dvd_r;
  logic [47:0]          q_r;
  logic signed [47:0]   cb_r [6];
  logic signed [47:0]   cw_r [6];
  lpc_result_t          res_r;

  logic signed [41:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [74:0]   mul_full;
  logic                 acc_clr, acc_ld;
  logic signed [127:0]  acc_ld_val;
  logic signed [127:0]  addend;
  logic [63:0]          mag, v;
  logic                 diag, t2_neg;
  logic [1:0]           ei, ej, ti, tj;
  logic signed [47:0]   cb_sel;
  logic [64:0]          div_t;
  logic                 div_ge;
  logic [64:0]          div_d;

  assign res = res_r;

  always_comb begin
    ei     = ent_i(e_r);
    ej     = ent_j(e_r);
    ti     = term_i(t_r);
    tj     = term_j(t_r);
    diag   = (ei == ej);
    mag    = pp_r[63] ? 64'(-pp_r) : 64'(pp_r);
    v      = diag ? item_r.r2 - mag : mag;
    t2_neg = !diag && !pp_r[63] && (pp_r != '0);
    cb_sel = cb_r[ent_idx(ti, tj)];
    div_t  = {rem_r, dvd_r[DIV_BITS-1]};
    div_ge = (div_t >= {1'b0, item_r.r2});
    div_d  = div_t - {1'b0, item_r.r2};
    mul_full = mul_a * mul_b;
    case (sh_r)
      SH_24:   addend = $signed(128'(mul_r)) <<< 24;
      SH_32:   addend = $signed(128'(mul_r)) <<< 32;
      default: addend = $signed(128'(mul_r));
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!q_empty) state_nxt = q_data.valid ? BK_RV : BK_OUT0;
      BK_RV:     state_nxt = BK_PP;
      BK_PP:     state_nxt = BK_PPCAP;
      BK_PPCAP:  state_nxt = BK_NLO;
      BK_NLO:    state_nxt = BK_NHI;
      BK_NHI:    state_nxt = BK_NWAIT;
      BK_NWAIT:  state_nxt = BK_DINIT;
      BK_DINIT:  state_nxt = BK_DIV;
      BK_DIV:    if (cnt_r == 6'(DIV_BITS - 1)) state_nxt = BK_T1;
      BK_T1:     state_nxt = BK_T2LO;
      BK_T2LO:   state_nxt = BK_T2HI;
      BK_T2HI:   state_nxt = BK_T2WAIT;
      BK_T2WAIT: state_nxt = BK_BRND;
      BK_BRND:   state_nxt = (e_r == 3'd5) ? BK_RR : BK_PP;
      BK_RR:     state_nxt = BK_RRCAP;
      BK_RRCAP:  state_nxt = BK_CLO;
      BK_CLO:    state_nxt = BK_CHI;
      BK_CHI:    state_nxt = (t_r == 4'd8) ? BK_CWAIT : BK_RR;
      BK_CWAIT:  state_nxt = BK_WRND;
      BK_WRND:   state_nxt = (e_r == 3'd5) ? BK_OUT0 : BK_RR;
      BK_OUT0:   state_nxt = BK_OUT1;
      BK_OUT1:   state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // datapath controls; a product is registered in mul_r, with its op_r and sh_r, before it is added into acc_r
  always_comb begin
    q_pop      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    op_nxt     = ACC_NONE;
    sh_nxt     = SH_0;
    acc_clr    = 1'b0;
    acc_ld     = 1'b0;
    acc_ld_val = '0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_RV: begin
        mul_a = {22'b0, cfg.range_std};
        mul_b = {13'b0, cfg.range_std};
      end
      BK_PP: begin
        mul_a = 42'(pt_sel(item_r, ei));
        mul_b = 33'(pt_sel(item_r, ej));
      end
      BK_NLO: begin
        acc_clr = 1'b1;
        mul_a   = {2'b0, rv_r};
        mul_b   = {1'b0, mag[31:0]};
        op_nxt  = ACC_ADD;
      end
      BK_NHI: begin
        mul_a  = {2'b0, rv_r};
        mul_b  = {1'b0, mag[63:32]};
        op_nxt = ACC_ADD;
        sh_nxt = SH_32;
      end
      BK_T1: begin
        acc_ld     = 1'b1;
        acc_ld_val = pp_r[63] ? -$signed({56'b0, q_r, 24'b0}) : $signed({56'b0, q_r, 24'b0});
      end
      BK_T2LO: begin
        mul_a  = {10'b0, cfg.beam_sine_sq};
        mul_b  = {1'b0, v[31:0]};
        op_nxt = t2_neg ? ACC_SUB : ACC_ADD;
      end
      BK_T2HI: begin
        mul_a  = {10'b0, cfg.beam_sine_sq};
        mul_b  = {1'b0, v[63:32]};
        op_nxt = t2_neg ? ACC_SUB : ACC_ADD;
        sh_nxt = SH_32;
      end
      BK_RR: begin
        acc_clr = (t_r == '0);
        mul_a   = 42'(rot_elem(cfg, ei, ti));
        mul_b   = 33'(rot_elem(cfg, ej, tj));
      end
      BK_CLO: begin
        mul_a  = rr_r;
        mul_b  = {9'b0, cb_sel[23:0]};
        op_nxt = ACC_ADD;
      end
      BK_CHI: begin
        mul_a  = rr_r;
        mul_b  = 33'($signed(cb_sel[47:24]));
        op_nxt = ACC_ADD;
        sh_nxt = SH_24;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (acc_clr) acc_nxt = '0;
    else if (acc_ld) acc_nxt = acc_ld_val;
    else if (op_r == ACC_ADD) acc_nxt = acc_r + addend;
    else if (op_r == ACC_SUB) acc_nxt = acc_r - addend;
    else acc_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      op_r         <= ACC_NONE;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    mul_r <= mul_full;
    acc_r <= acc_nxt;
    res_r.strobe <= rst_n && ((state_r == BK_OUT0) || (state_r == BK_OUT1));
    case (state_r)
      BK_IDLE: begin
        item_r <= q_data;
        e_r    <= '0;
        t_r    <= '0;
      end
      BK_PP:    if (e_r == '0) rv_r <= mul_r[39:0];
      BK_PPCAP: pp_r <= mul_r[63:0];
      BK_DINIT: begin
        // dividend is acc << 8; its top part is already below r2
        rem_r <= acc_r[103:40];
        dvd_r <= {acc_r[39:0], 8'b0};
        cnt_r <= '0;
      end
      BK_DIV: begin
        rem_r <= div_ge ? div_d[63:0] : div_t[63:0];
        q_r   <= {q_r[DIV_BITS-2:0], div_ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
      end
      BK_BRND: begin
        cb_r[e_r] <= round_sat(acc_r, BODY_SH);
        e_r       <= (e_r == 3'd5) ? 3'd0 : e_r + 1'b1;
        t_r       <= '0;
      end
      BK_RRCAP: rr_r <= mul_r[41:0];
      BK_CHI:   t_r <= t_r + 1'b1;
      BK_WRND: begin
        cw_r[e_r] <= round_sat(acc_r, WORLD_SH);
        e_r       <= e_r + 1'b1;
        t_r       <= '0;
      end
      BK_OUT0: begin
        res_r.frame_sel <= 1'b0;
        res_r.last      <= 1'b0;
        res_r.cov_valid <= item_r.valid;
        res_r.xx <= item_r.valid ? cb_r[0] : '0;
        res_r.xy <= item_r.valid ? cb_r[1] : '0;
        res_r.xz <= item_r.valid ? cb_r[2] : '0;
        res_r.yy <= item_r.valid ? cb_r[3] : '0;
        res_r.yz <= item_r.valid ? cb_r[4] : '0;
        res_r.zz <= item_r.valid ? cb_r[5] : '0;
      end
      BK_OUT1: begin
        res_r.frame_sel <= 1'b1;
        res_r.last      <= 1'b1;
        res_r.cov_valid <= item_r.valid;
        res_r.xx <= item_r.valid ? cw_r[0] : '0;
        res_r.xy <= item_r.valid ? cw_r[1] : '0;
        res_r.xz <= item_r.valid ? cw_r[2] : '0;
        res_r.yy <= item_r.valid ? cw_r[3] : '0;
        res_r.yz <= item_r.valid ? cw_r[4] : '0;
        res_r.zz <= item_r.valid ? cw_r[5] : '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/lidar_point_covariance.sv
// Top level of the lidar point covariance block: config registers, front, queue, back.
`timescale 1ns / 1ps
// Usage:
//   Input: a point (x, y, z, no_return) is taken on a clock edge with start high and
//   busy low. busy rises only when the two-entry queue and the front stage are full.
//   Config: cfg_we with cfg_index/cfg_wdata writes one register per edge; write only
//   while no point is in flight.
//   Results: two per point, each on the out_ ports for one cycle with out_strobe high:
//   body-frame covariance (frame_sel 0) then world-frame (frame_sel 1, last_of_point 1).
//   The receiver cannot stall; results are never held.
//   Back end: one shared 42x33 multiplier and a one-bit-per-cycle divider. A valid
//   point occupies it for 6 body entries, each with a divide, then 6 world entries;
//   an invalid point goes straight to its results. It pops a point only when idle.
//   Order: an accepted point goes from the front stage through the queue to the back
//   end; its world-frame result is on the out_ ports in the cycle after its body-frame
//   result, and time spent waiting in the queue delays both.
//   Reset: synchronous, active low; clears control and restores the register defaults
//   (identity rotation). There is no clearing pass.
module lidar_point_covariance #(
  parameter int unsigned COV_FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               in_no_return,
  output logic               out_strobe,
  output logic               out_frame_sel,
  output logic signed [47:0] out_cov_xx,
  output logic signed [47:0] out_cov_xy,
  output logic signed [47:0] out_cov_xz,
  output logic signed [47:0] out_cov_yy,
  output logic signed [47:0] out_cov_yz,
  output logic signed [47:0] out_cov_zz,
  output logic               out_cov_valid,
  output logic               out_last_of_point,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [62:0]        cfg_wdata
);
  import lpc_pkg::*;

  lpc_cfg_t    cfg_r;
  lpc_item_t   push_data, pop_data;
  logic        push, q_full, q_pop, q_empty;
  lpc_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_std    <= 20'd1311;
      cfg_r.beam_sine_sq <= 32'd13080;
      cfg_r.rot[0]       <= 63'd524288;
      cfg_r.rot[1]       <= 63'd1099511627776;
      cfg_r.rot[2]       <= 63'd2305843009213693952;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_STD: cfg_r.range_std    <= cfg_wdata[19:0];
        CFG_BEAM_SSQ:  cfg_r.beam_sine_sq <= cfg_wdata[31:0];
        CFG_ROT_ROW0:  cfg_r.rot[0]       <= cfg_wdata;
        CFG_ROT_ROW1:  cfg_r.rot[1]       <= cfg_wdata;
        CFG_ROT_ROW2:  cfg_r.rot[2]       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .in_no_return (in_no_return),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  lpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  lpc_back #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .res     (res)
  );

  assign out_strobe        = res.strobe;
  assign out_frame_sel     = res.frame_sel;
  assign out_cov_xx        = res.xx;
  assign out_cov_xy        = res.xy;
  assign out_cov_xz        = res.xz;
  assign out_cov_yy        = res.yy;
  assign out_cov_yz        = res.yz;
  assign out_cov_zz        = res.zz;
  assign out_cov_valid     = res.cov_valid;
  assign out_last_of_point = res.last;

endmodule
